// ===== hdl/brace_balanced_content_scanner_top_assert.svh =====
// Assertion macros used by the scanner lexer.
`ifndef BRACE_BALANCED_CONTENT_SCANNER_TOP_ASSERT_SVH
`define BRACE_BALANCED_CONTENT_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBCS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bbcs_pkg.sv =====
// Package: request/response types, codes and character constants of the scanner.
`timescale 1ns / 1ps
package bbcs_pkg;

  localparam int unsigned CharBits = 21;

  // Response action codes
  localparam logic [1:0] ACT_SKIP    = 2'd0;
  localparam logic [1:0] ACT_CONSUME = 2'd1;
  localparam logic [1:0] ACT_HOLD    = 2'd2;

  // Characters of interest
  localparam logic [CharBits-1:0] CH_NEWLINE = 21'h00000A;
  localparam logic [CharBits-1:0] CH_LBRACE  = 21'h00007B;
  localparam logic [CharBits-1:0] CH_RBRACE  = 21'h00007D;
  localparam logic [CharBits-1:0] CH_SLASH   = 21'h00002F;
  localparam logic [CharBits-1:0] CH_STAR    = 21'h00002A;
  localparam logic [CharBits-1:0] CH_DQUOTE  = 21'h000022;
  localparam logic [CharBits-1:0] CH_SQUOTE  = 21'h000027;
  localparam logic [CharBits-1:0] CH_BTICK   = 21'h000060;
  localparam logic [CharBits-1:0] CH_DOLLAR  = 21'h000024;
  localparam logic [CharBits-1:0] CH_BSLASH  = 21'h00005C;
  localparam logic [CharBits-1:0] CH_AT      = 21'h000040;
  localparam logic [CharBits-1:0] CH_PERCENT = 21'h000025;
  localparam logic [CharBits-1:0] CH_DOT     = 21'h00002E;
  localparam logic [CharBits-1:0] CH_HASH    = 21'h000023;

  typedef struct packed {
    logic                start_req;
    logic                content_allowed;
    logic                end_of_input;
    logic [CharBits-1:0] character;
  } in_req_t;

  typedef struct packed {
    logic [1:0] action;
    logic       scan_done;
    logic       token_found;
  } out_rsp_t;

  // Character class flags handed from the classifier to the lexer
  typedef struct packed {
    logic is_ws;
    logic is_refuse;
    logic is_newline;
    logic is_lbrace;
    logic is_rbrace;
    logic is_slash;
    logic is_star;
    logic is_dquote;
    logic is_squote;
    logic is_btick;
    logic is_dollar;
    logic is_bslash;
  } char_class_t;

endpackage

// ===== hdl/bbcs_char_class.sv =====
// Character classifier: decodes one code point into lexer class flags.
`timescale 1ns / 1ps
module bbcs_char_class (
  input  logic [bbcs_pkg::CharBits-1:0] character_i,
  output bbcs_pkg::char_class_t         cls_o
);
  import bbcs_pkg::*;

  logic ws_ascii;
  logic ws_uni;

  // Whitespace: ASCII controls, space, and a subset of the Unicode spaces and line separators
  assign ws_ascii = ((character_i >= 21'd9) && (character_i <= 21'd13)) ||
                    (character_i == 21'd32);
  assign ws_uni   = (character_i == 21'h000085) || (character_i == 21'h001680) ||
                    ((character_i >= 21'h002000) && (character_i <= 21'h002006)) ||
                    ((character_i >= 21'h002008) && (character_i <= 21'h00200A)) ||
                    (character_i == 21'h002028) || (character_i == 21'h002029) ||
                    (character_i == 21'h00205F) || (character_i == 21'h003000);

  // Decode single punctuation characters
  always_comb begin
    cls_o.is_ws      = ws_ascii | ws_uni;
    cls_o.is_newline = (character_i == CH_NEWLINE);
    cls_o.is_lbrace  = (character_i == CH_LBRACE);
    cls_o.is_rbrace  = (character_i == CH_RBRACE);
    cls_o.is_slash   = (character_i == CH_SLASH);
    cls_o.is_star    = (character_i == CH_STAR);
    cls_o.is_dquote  = (character_i == CH_DQUOTE);
    cls_o.is_squote  = (character_i == CH_SQUOTE);
    cls_o.is_btick   = (character_i == CH_BTICK);
    cls_o.is_dollar  = (character_i == CH_DOLLAR);
    cls_o.is_bslash  = (character_i == CH_BSLASH);
    // Characters that cannot open a content token
    cls_o.is_refuse  = (character_i == CH_RBRACE) || (character_i == CH_AT) ||
                       (character_i == CH_PERCENT) || (character_i == CH_DOT) ||
                       (character_i == CH_HASH) || (character_i == CH_SLASH);
  end

endmodule

// ===== hdl/bbcs_lexer.sv =====
// Lexer: lexical mode, brace and interpolation depth, and per-request response.
`timescale 1ns / 1ps
module bbcs_lexer #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  bbcs_pkg::in_req_t     req_i,
  input  bbcs_pkg::char_class_t cls_i,
  output bbcs_pkg::out_rsp_t    rsp_o
);
  import bbcs_pkg::*;

`include "brace_balanced_content_scanner_top_assert.svh"

  typedef enum logic [3:0] {
    MODE_IDLE        = 4'd0,
    MODE_WS_ON       = 4'd1,
    MODE_WS_OFF      = 4'd2,
    MODE_MAIN        = 4'd3,
    MODE_SLASH       = 4'd4,
    MODE_LINE        = 4'd5,
    MODE_BLOCK       = 4'd6,
    MODE_BLOCK_STAR  = 4'd7,
    MODE_DQ          = 4'd8,
    MODE_DQ_ESC      = 4'd9,
    MODE_SQ          = 4'd10,
    MODE_SQ_ESC      = 4'd11,
    MODE_TMPL        = 4'd12,
    MODE_TMPL_DOLLAR = 4'd13,
    MODE_TMPL_ESC    = 4'd14,
    MODE_INTERP      = 4'd15
  } lex_mode_e;

  localparam logic [DEPTH_BITS-1:0] DepthZero = '0;
  localparam logic [DEPTH_BITS-1:0] DepthOne  = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
  localparam logic [DEPTH_BITS-1:0] DepthMax  = '1;

  lex_mode_e             mode_q, mode_d, mode_v;
  logic [DEPTH_BITS-1:0] brace_q, brace_d, brace_v;
  logic [DEPTH_BITS-1:0] interp_q, interp_d, interp_v;
  logic                  seen_q, seen_d, seen_v;
  logic                  do_main;
  logic                  do_tmpl;

  // Next state and response for the request in the input register
  always_comb begin
    // Start opens a fresh scan before anything else is looked at
    mode_v   = mode_q;
    brace_v  = brace_q;
    interp_v = interp_q;
    seen_v   = seen_q;
    if (req_i.start_req) begin
      mode_v   = req_i.content_allowed ? MODE_WS_ON : MODE_WS_OFF;
      brace_v  = DepthOne;
      interp_v = DepthZero;
      seen_v   = 1'b0;
    end

    mode_d   = mode_v;
    brace_d  = brace_v;
    interp_d = interp_v;
    seen_d   = seen_v;
    rsp_o    = '{action: ACT_CONSUME, scan_done: 1'b0, token_found: 1'b0};
    do_main  = 1'b0;
    do_tmpl  = 1'b0;

    unique case (mode_v) inside
      MODE_IDLE: begin
        rsp_o.action = ACT_HOLD;
      end
      MODE_WS_ON, MODE_WS_OFF: begin
        if (!req_i.end_of_input && cls_i.is_ws) begin
          rsp_o.action = ACT_SKIP;
        end else if ((mode_v == MODE_WS_OFF) || req_i.end_of_input || cls_i.is_refuse) begin
          // Refuse the token
          mode_d          = MODE_IDLE;
          rsp_o.action    = ACT_HOLD;
          rsp_o.scan_done = 1'b1;
        end else begin
          do_main = 1'b1;
        end
      end
      default: begin
        if (req_i.end_of_input) begin
          mode_d            = MODE_IDLE;
          rsp_o.action      = ACT_HOLD;
          rsp_o.scan_done   = 1'b1;
          rsp_o.token_found = seen_v;
        end else begin
          case (mode_v)
            MODE_MAIN: do_main = 1'b1;
            MODE_SLASH: begin
              if (cls_i.is_slash) begin
                mode_d = MODE_LINE;
              end else if (cls_i.is_star) begin
                mode_d = MODE_BLOCK;
              end else begin
                do_main = 1'b1;
              end
            end
            MODE_LINE: begin
              // Newline ends the comment and is handled as content
              if (cls_i.is_newline) begin
                do_main = 1'b1;
              end
            end
            MODE_BLOCK: begin
              if (cls_i.is_star) begin
                mode_d = MODE_BLOCK_STAR;
              end
            end
            MODE_BLOCK_STAR: begin
              if (cls_i.is_slash) begin
                mode_d = MODE_MAIN;
              end else if (!cls_i.is_star) begin
                mode_d = MODE_BLOCK;
              end
            end
            MODE_DQ: begin
              if (cls_i.is_bslash) begin
                mode_d = MODE_DQ_ESC;
              end else if (cls_i.is_dquote) begin
                mode_d = MODE_MAIN;
              end
            end
            MODE_DQ_ESC: mode_d = MODE_DQ;
            MODE_SQ: begin
              if (cls_i.is_bslash) begin
                mode_d = MODE_SQ_ESC;
              end else if (cls_i.is_squote) begin
                mode_d = MODE_MAIN;
              end
            end
            MODE_SQ_ESC: mode_d = MODE_SQ;
            MODE_TMPL: do_tmpl = 1'b1;
            MODE_TMPL_DOLLAR: begin
              if (cls_i.is_lbrace) begin
                interp_d = DepthOne;
                mode_d   = MODE_INTERP;
              end else begin
                do_tmpl = 1'b1;
              end
            end
            MODE_TMPL_ESC: mode_d = MODE_TMPL;
            MODE_INTERP: begin
              if (cls_i.is_lbrace) begin
                if (interp_v != DepthMax) begin
                  interp_d = interp_v + DepthOne;
                end
              end else if (cls_i.is_rbrace) begin
                if (interp_v <= DepthOne) begin
                  interp_d = DepthZero;
                  mode_d   = MODE_TMPL;
                end else begin
                  interp_d = interp_v - DepthOne;
                end
              end
            end
            default: rsp_o.action = ACT_HOLD;
          endcase
        end
      end
    endcase

    // Plain content: track braces and enter quoted or comment modes
    if (do_main) begin
      mode_d = MODE_MAIN;
      seen_d = 1'b1;
      if (cls_i.is_rbrace) begin
        if (brace_v <= DepthOne) begin
          // Closing brace at the outer level ends the token unconsumed
          brace_d           = DepthZero;
          mode_d            = MODE_IDLE;
          seen_d            = seen_v;
          rsp_o.action      = ACT_HOLD;
          rsp_o.scan_done   = 1'b1;
          rsp_o.token_found = seen_v;
        end else begin
          brace_d = brace_v - DepthOne;
        end
      end else if (cls_i.is_lbrace) begin
        if (brace_v != DepthMax) begin
          brace_d = brace_v + DepthOne;
        end
      end else if (cls_i.is_slash) begin
        mode_d = MODE_SLASH;
      end else if (cls_i.is_dquote) begin
        mode_d = MODE_DQ;
      end else if (cls_i.is_squote) begin
        mode_d = MODE_SQ;
      end else if (cls_i.is_btick) begin
        mode_d = MODE_TMPL;
      end
    end

    // Template body
    if (do_tmpl) begin
      mode_d = MODE_TMPL;
      if (cls_i.is_btick) begin
        mode_d = MODE_MAIN;
      end else if (cls_i.is_dollar) begin
        mode_d = MODE_TMPL_DOLLAR;
      end else if (cls_i.is_bslash) begin
        mode_d = MODE_TMPL_ESC;
      end
    end
  end

  // Advance the scan state once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      brace_q  <= DepthOne;
      interp_q <= DepthZero;
      seen_q   <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      brace_q  <= brace_d;
      interp_q <= interp_d;
      seen_q   <= seen_d;
    end
  end

  `BBCS_ASSERT_NEXT(a_done_goes_idle, clk_i, rst_ni, step_i && rsp_o.scan_done, mode_q == MODE_IDLE, "scan ended but mode not idle")
  `BBCS_ASSERT_NOW(a_interp_nonzero, clk_i, rst_ni, mode_q == MODE_INTERP, interp_q != DepthZero, "interpolation mode with zero depth")
  `BBCS_ASSERT_NOW(a_found_needs_done, clk_i, rst_ni, !rsp_o.scan_done, !rsp_o.token_found, "token found without scan end")
  `BBCS_ASSERT_NEXT(a_hold_when_idle, clk_i, rst_ni, !step_i, $stable(mode_q) && $stable(brace_q) && $stable(seen_q), "scan state moved without a request")

endmodule

// ===== hdl/brace_balanced_content_scanner_top.sv =====
// Top level: input register, character classifier, lexer and response register.
`timescale 1ns / 1ps
// Brace-balanced content scanner. Takes one character request per clock cycle,
// back to back while in_stall_o is low, and returns exactly one response per
// request, in order. A response is presented on the output once its request
// has passed the input register and then the response register, and is taken
// when the output side does not stall. The lexical mode and depth counters in
// bbcs_lexer are updated once per request, closing one request per cycle while
// the output side does not stall. The input side keeps taking requests while a
// finished response waits to be taken, as long as the input register is free;
// in_stall_o rises only when both registers are full and the output is
// stalled. Brace and interpolation depth are DEPTH_BITS wide and saturate at
// their maximum.
module brace_balanced_content_scanner_top #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bbcs_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bbcs_pkg::out_rsp_t out_rsp_o
);
  import bbcs_pkg::*;

  logic        in_valid_q;
  in_req_t     in_req_q;
  logic        out_valid_q;
  out_rsp_t    out_rsp_q;
  out_rsp_t    rsp;
  char_class_t cls;
  logic        out_free;
  logic        step;
  logic        in_take;

  // Handshake: a request moves on when the response register can load
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
  end

  bbcs_char_class u_char_class (
    .character_i (in_req_q.character),
    .cls_o       (cls)
  );

  bbcs_lexer #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_req_q),
    .cls_i  (cls),
    .rsp_o  (rsp)
  );

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the brace-balanced content scanner: directed and random requests against a predictor.
module tb;
  import bbcs_pkg::*;

  localparam int unsigned DepthBits = 16;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports = 60;
  localparam int unsigned NestLevels = 24;
  localparam logic [DepthBits-1:0] DepthMax = '1;

  // Lexer modes of the scan predictor
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_WS_ON,
    MODE_WS_OFF,
    MODE_MAIN,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BLOCK_STAR,
    MODE_DQ,
    MODE_DQ_ESC,
    MODE_SQ,
    MODE_SQ_ESC,
    MODE_TMPL,
    MODE_TMPL_DOLLAR,
    MODE_TMPL_ESC,
    MODE_INTERP
  } scan_mode_e;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  brace_balanced_content_scanner_top #(
    .DEPTH_BITS(DepthBits)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  // Predictor state
  scan_mode_e           scan_mode = MODE_IDLE;
  logic [DepthBits-1:0] nest_depth = DepthBits'(1);
  logic [DepthBits-1:0] tmpl_depth = '0;
  logic                 saw_content = 1'b0;

  out_rsp_t             scan_rsp_q[$];
  logic [CharBits-1:0]  token_q[$];

  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned gap_max = 0;
  int unsigned stall_pct = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [CharBits-1:0] ch(byte b);
    return {13'd0, b};
  endfunction

  function automatic bit is_space(logic [CharBits-1:0] c);
    return (c >= 9 && c <= 13) || c == 32 || c == 'h85 || c == 'h1680 ||
           (c >= 'h2000 && c <= 'h2006) || (c >= 'h2008 && c <= 'h200A) ||
           c == 'h2028 || c == 'h2029 || c == 'h205F || c == 'h3000;
  endfunction

  function automatic bit is_refused(logic [CharBits-1:0] c);
    return c == CH_RBRACE || c == CH_AT || c == CH_PERCENT || c == CH_DOT ||
           c == CH_HASH || c == CH_SLASH;
  endfunction

  // Advance the predictor by one request and return the response it causes
  function automatic out_rsp_t predict_rsp(in_req_t req);
    out_rsp_t            rsp;
    logic [CharBits-1:0] c;
    bit                  again;
    c = req.character;
    rsp = '{action: ACT_HOLD, scan_done: 1'b0, token_found: 1'b0};
    if (req.start_req) begin
      scan_mode = req.content_allowed ? MODE_WS_ON : MODE_WS_OFF;
      nest_depth = DepthBits'(1);
      tmpl_depth = '0;
      saw_content = 1'b0;
    end
    if (scan_mode == MODE_IDLE) return rsp;
    // Skip leading whitespace, refuse content where it cannot start
    if (scan_mode == MODE_WS_ON || scan_mode == MODE_WS_OFF) begin
      if (!req.end_of_input && is_space(c)) begin
        rsp.action = ACT_SKIP;
        return rsp;
      end
      if (scan_mode == MODE_WS_OFF || req.end_of_input || is_refused(c)) begin
        scan_mode = MODE_IDLE;
        rsp.scan_done = 1'b1;
        return rsp;
      end
      scan_mode = MODE_MAIN;
    end
    if (req.end_of_input) begin
      scan_mode = MODE_IDLE;
      rsp.scan_done = 1'b1;
      rsp.token_found = saw_content;
      return rsp;
    end
    rsp.action = ACT_CONSUME;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (scan_mode)
        MODE_MAIN: begin
          if (c == CH_RBRACE && nest_depth <= 1) begin
            nest_depth = '0;
            scan_mode = MODE_IDLE;
            rsp = '{action: ACT_HOLD, scan_done: 1'b1, token_found: saw_content};
          end else begin
            if (c == CH_RBRACE) begin
              nest_depth--;
            end else if (c == CH_LBRACE) begin
              if (nest_depth < DepthMax) nest_depth++;
            end else if (c == CH_SLASH) begin
              scan_mode = MODE_SLASH;
            end else if (c == CH_DQUOTE) begin
              scan_mode = MODE_DQ;
            end else if (c == CH_SQUOTE) begin
              scan_mode = MODE_SQ;
            end else if (c == CH_BTICK) begin
              scan_mode = MODE_TMPL;
            end
            saw_content = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            scan_mode = MODE_LINE;
          end else if (c == CH_STAR) begin
            scan_mode = MODE_BLOCK;
          end else begin
            scan_mode = MODE_MAIN;
            again = 1'b1;
          end
        end
        MODE_LINE: begin
          if (c == CH_NEWLINE) begin
            scan_mode = MODE_MAIN;
            again = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) scan_mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (c == CH_SLASH) scan_mode = MODE_MAIN;
          else if (c != CH_STAR) scan_mode = MODE_BLOCK;
        end
        MODE_DQ: begin
          if (c == CH_BSLASH) scan_mode = MODE_DQ_ESC;
          else if (c == CH_DQUOTE) scan_mode = MODE_MAIN;
        end
        MODE_DQ_ESC: scan_mode = MODE_DQ;
        MODE_SQ: begin
          if (c == CH_BSLASH) scan_mode = MODE_SQ_ESC;
          else if (c == CH_SQUOTE) scan_mode = MODE_MAIN;
        end
        MODE_SQ_ESC: scan_mode = MODE_SQ;
        MODE_TMPL: begin
          if (c == CH_BTICK) scan_mode = MODE_MAIN;
          else if (c == CH_DOLLAR) scan_mode = MODE_TMPL_DOLLAR;
          else if (c == CH_BSLASH) scan_mode = MODE_TMPL_ESC;
        end
        MODE_TMPL_DOLLAR: begin
          if (c == CH_LBRACE) begin
            tmpl_depth = DepthBits'(1);
            scan_mode = MODE_INTERP;
          end else begin
            scan_mode = MODE_TMPL;
            again = 1'b1;
          end
        end
        MODE_TMPL_ESC: scan_mode = MODE_TMPL;
        MODE_INTERP: begin
          if (c == CH_LBRACE) begin
            if (tmpl_depth < DepthMax) tmpl_depth++;
          end else if (c == CH_RBRACE) begin
            if (tmpl_depth <= 1) begin
              tmpl_depth = '0;
              scan_mode = MODE_TMPL;
            end else begin
              tmpl_depth--;
            end
          end
        end
        default: begin
          scan_mode = MODE_IDLE;
          rsp.action = ACT_HOLD;
        end
      endcase
    end
    return rsp;
  endfunction

  task automatic report_field(string name, logic [1:0] want, logic [1:0] got);
    if (want !== got) begin
      mismatch_count++;
      // keep the log short once a run has gone wrong
      if (mismatch_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Check each response, track progress, drive the receiver stall pattern
  always @(posedge clk) begin : check_rsp
    out_rsp_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (scan_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: response with none pending, expected none, got %0d/%0d/%0d",
                     $time, out_rsp.action, out_rsp.scan_done, out_rsp.token_found);
        end else begin
          want = scan_rsp_q.pop_front();
          report_field("action", want.action, out_rsp.action);
          report_field("scan_done", 2'(want.scan_done), 2'(out_rsp.scan_done));
          report_field("token_found", 2'(want.token_found), 2'(out_rsp.token_found));
        end
      end
      if (stall_left == 0) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        stall_left <= $urandom_range(1, 8);
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  initial begin : watchdog
    @(posedge clk);
    while (stuck_cycles < StuckLimit) @(posedge clk);
    $display("%0t: nothing moved for %0d cycles", $time, StuckLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  // Send one request: open a gap between bursts, hold until accepted, predict
  task automatic send_char(bit start, bit allow, bit eof, logic [CharBits-1:0] c);
    in_req_t     req;
    int unsigned gap_len;
    req.start_req = start;
    req.content_allowed = allow;
    req.end_of_input = eof;
    req.character = c;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_len = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_rsp_q.push_back(predict_rsp(req));
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(1'b0, 1'b0, 1'b0, ch(s[i]));
  endtask

  // Drop valid and hold until every pending response has come back
  task automatic wait_for_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scan_rsp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CharBits-1:0] pick_space();
    case ($urandom_range(0, 10))
      0: return 21'($urandom_range(9, 13));
      1: return 21'd32;
      2: return 21'h85;
      3: return 21'h1680;
      4: return 21'($urandom_range('h2000, 'h2006));
      5: return 21'($urandom_range('h2008, 'h200A));
      6: return 21'h2028;
      7: return 21'h2029;
      8: return 21'h205F;
      9: return 21'h3000;
      default: return 21'd32;
    endcase
  endfunction

  // Characters the lexer reacts to, plus near misses of the whitespace set
  function automatic logic [CharBits-1:0] pick_special();
    case ($urandom_range(0, 17))
      0: return CH_NEWLINE;
      1: return CH_LBRACE;
      2: return CH_RBRACE;
      3: return CH_SLASH;
      4: return CH_STAR;
      5: return CH_DQUOTE;
      6: return CH_SQUOTE;
      7: return CH_BTICK;
      8: return CH_DOLLAR;
      9: return CH_BSLASH;
      10: return CH_AT;
      11: return CH_PERCENT;
      12: return CH_DOT;
      13: return CH_HASH;
      14: return 21'hA0;
      15: return 21'h2007;
      16: return 21'h202F;
      default: return 21'hFEFF;
    endcase
  endfunction

  function automatic logic [CharBits-1:0] pick_any();
    case ($urandom_range(0, 5))
      0: return 21'($urandom_range(0, 'h10FFFF));
      1: return pick_space();
      2: return 21'($urandom_range(0, 127));
      3: return pick_special();
      4: return 21'($urandom_range('h80, 'hFFFF));
      default: return 21'($urandom_range(97, 122));
    endcase
  endfunction

  // Plain content; braces only where the caller allows them
  function automatic logic [CharBits-1:0] pick_filler(bit braces);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 21'($urandom_range(97, 122));
    if (r == 6) return pick_space();
    if (r == 7) return 21'($urandom_range('h80, 'h10FFFF));
    if (r == 8 || !braces) return 21'($urandom_range(48, 57));
    return ($urandom_range(0, 1) != 0) ? CH_LBRACE : CH_RBRACE;
  endfunction

  task automatic add_quoted(logic [CharBits-1:0] q);
    token_q.push_back(q);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) begin
        token_q.push_back(CH_BSLASH);
        token_q.push_back(pick_any());
      end else begin
        token_q.push_back(pick_filler(1'b1));
      end
    end
    token_q.push_back(q);
  endtask

  task automatic add_template();
    token_q.push_back(CH_BTICK);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 3))
        0: token_q.push_back(pick_filler(1'b1));
        1: begin
          token_q.push_back(CH_BSLASH);
          token_q.push_back(pick_any());
        end
        2: begin
          token_q.push_back(CH_DOLLAR);
          token_q.push_back(pick_filler(1'b0));
        end
        default: begin
          token_q.push_back(CH_DOLLAR);
          token_q.push_back(CH_LBRACE);
          repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) != 0) begin
              token_q.push_back(pick_filler(1'b0));
            end else begin
              token_q.push_back(CH_LBRACE);
              token_q.push_back(pick_filler(1'b0));
              token_q.push_back(CH_RBRACE);
            end
          end
          token_q.push_back(CH_RBRACE);
        end
      endcase
    end
    token_q.push_back(CH_BTICK);
  endtask

  // Append one well-formed piece of content
  task automatic add_piece(int unsigned lvl);
    case ($urandom_range(0, 6))
      0: repeat ($urandom_range(1, 4)) token_q.push_back(pick_filler(1'b0));
      1: begin
        if (lvl < 3) begin
          token_q.push_back(CH_LBRACE);
          repeat ($urandom_range(0, 3)) add_piece(lvl + 1);
          token_q.push_back(CH_RBRACE);
        end else begin
          token_q.push_back(pick_filler(1'b0));
        end
      end
      2: begin
        token_q.push_back(CH_SLASH);
        token_q.push_back(CH_SLASH);
        repeat ($urandom_range(0, 4)) token_q.push_back(pick_filler(1'b1));
        token_q.push_back(CH_NEWLINE);
      end
      3: begin
        token_q.push_back(CH_SLASH);
        token_q.push_back(CH_STAR);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 3))
            0: token_q.push_back(CH_STAR);
            1: token_q.push_back(CH_SLASH);
            default: token_q.push_back(pick_filler(1'b1));
          endcase
        end
        token_q.push_back(CH_STAR);
        token_q.push_back(CH_SLASH);
      end
      4: add_quoted(CH_DQUOTE);
      5: add_quoted(CH_SQUOTE);
      default: add_template();
    endcase
  endtask

  // One scan: optional whitespace, content pieces, then an ending
  task automatic run_token();
    bit          allow;
    int unsigned ending;
    token_q.delete();
    allow = ($urandom_range(0, 9) != 0);
    repeat ($urandom_range(0, 2)) token_q.push_back(pick_space());
    repeat ($urandom_range(1, 4)) add_piece(0);
    // break the sequence now and then
    if ($urandom_range(0, 7) == 0)
      token_q.insert($urandom_range(0, token_q.size() - 1), pick_any());
    if ($urandom_range(0, 9) == 0 && token_q.size() > 1)
      token_q.delete($urandom_range(0, token_q.size() - 1));
    for (int i = 0; i < token_q.size(); i++)
      send_char(i == 0, (i == 0) ? allow : 1'($urandom_range(0, 1)), 1'b0, token_q[i]);
    ending = $urandom_range(0, 9);
    if (ending < 7) send_char(1'b0, 1'($urandom_range(0, 1)), 1'b0, CH_RBRACE);
    else if (ending < 9) send_char(1'b0, 1'($urandom_range(0, 1)), 1'b1, pick_any());
    // otherwise leave the scan open for the next start to abandon
    if ($urandom_range(0, 4) == 0) send_char(1'b0, 1'($urandom_range(0, 1)), 1'b0, pick_any());
  endtask

  task automatic test_outside_scan();
    send_char(1'b0, 1'b1, 1'b0, ch("a"));
  endtask

  task automatic test_refusals();
    send_char(1'b1, 1'b0, 1'b0, ch("a"));   // content not allowed
    send_char(1'b1, 1'b1, 1'b1, ch(" "));   // end of input ignores the character
    send_char(1'b1, 1'b1, 1'b0, CH_RBRACE);
    send_char(1'b1, 1'b1, 1'b0, CH_SLASH);
    send_char(1'b1, 1'b1, 1'b0, CH_HASH);
  endtask

  task automatic test_whitespace_extremes();
    send_char(1'b1, 1'b1, 1'b0, 21'h3000);
    send_char(1'b0, 1'b0, 1'b0, 21'h0);
    send_char(1'b0, 1'b1, 1'b0, 21'h10FFFF);
    send_char(1'b0, 1'b0, 1'b1, 21'h10FFFF);
  endtask

  task automatic test_comments_and_strings();
    send_char(1'b1, 1'b1, 1'b0, ch("a"));
    send_text("{//}\n}/*}**/\"\\\"}\"'}'");
    send_char(1'b0, 1'b0, 1'b0, CH_RBRACE);
  endtask

  task automatic test_templates();
    send_char(1'b1, 1'b1, 1'b0, CH_BTICK);
    send_text("$x${{}}\\");
    send_char(1'b0, 1'b0, 1'b0, CH_BTICK);
    send_char(1'b0, 1'b0, 1'b0, CH_BTICK);
    // abandon the running scan with a new start
    send_char(1'b1, 1'b1, 1'b0, CH_LBRACE);
    send_char(1'b0, 1'b0, 1'b1, 21'h0);
  endtask

  task automatic test_random_tokens();
    int unsigned target;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_max = 0;  stall_pct = 0;  end
        1: begin gap_max = 12; stall_pct = 30; end
        2: begin gap_max = 3;  stall_pct = 70; end
        default: begin gap_max = 20; stall_pct = 10; end
      endcase
      target = items_sent + 240;
      while (items_sent < target) run_token();
      wait_for_responses();
    end
  endtask

  task automatic test_random_noise();
    int unsigned target;
    gap_max = 6;
    stall_pct = 40;
    target = items_sent + 250;
    while (items_sent < target)
      send_char($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                $urandom_range(0, 7) == 0, pick_any());
    wait_for_responses();
  endtask

  // Nest both depth counters deep and unwind them again
  task automatic test_deep_nesting();
    gap_max = 0;
    stall_pct = 0;
    send_char(1'b1, 1'b1, 1'b0, CH_LBRACE);
    repeat (NestLevels) send_char(1'b0, 1'b0, 1'b0, CH_LBRACE);
    repeat (NestLevels + 1) send_char(1'b0, 1'b0, 1'b0, CH_RBRACE);
    send_char(1'b0, 1'b0, 1'b0, CH_RBRACE);
    send_char(1'b1, 1'b1, 1'b0, CH_BTICK);
    send_char(1'b0, 1'b0, 1'b0, CH_DOLLAR);
    send_char(1'b0, 1'b0, 1'b0, CH_LBRACE);
    repeat (NestLevels) send_char(1'b0, 1'b0, 1'b0, CH_LBRACE);
    repeat (NestLevels) send_char(1'b0, 1'b0, 1'b0, CH_RBRACE);
    send_char(1'b0, 1'b0, 1'b0, CH_RBRACE);
    send_char(1'b0, 1'b0, 1'b0, CH_BTICK);
    send_char(1'b0, 1'b0, 1'b0, CH_RBRACE);
    wait_for_responses();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_max = 4;
    stall_pct = 25;
    test_outside_scan();
    test_refusals();
    test_whitespace_extremes();
    test_comments_and_strings();
    test_templates();
    wait_for_responses();
    test_random_tokens();
    test_random_noise();
    test_deep_nesting();
    wait_for_responses();
    repeat (DrainCycles) @(posedge clk);
    if (scan_rsp_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, scan_rsp_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
